/* design/i2cm_pkg.sv */
`default_nettype none
package i2cm_pkg;

	localparam int BYTE_BITS = 8;
	localparam int CNT_W = $clog2(BYTE_BITS + 1);
	localparam int HP_W = 16;
	localparam logic [HP_W-1:0] HALF_PERIOD_RESET = HP_W'(250);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_HIGH  = 3'd1;
	localparam logic [2:0] PH_LOW   = 3'd2;
	localparam logic [2:0] PH_AHIGH = 3'd3;
	localparam logic [2:0] PH_ALOW  = 3'd4;

	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_STOP  = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_READ  = 3'd3;
	localparam logic [2:0] CMD_SACK  = 3'd4;
	localparam logic [2:0] CMD_RACK  = 3'd5;

	typedef struct packed {
		logic                 cmd_valid;
		logic [2:0]           command;
		logic [BYTE_BITS-1:0] write_data;
		logic                 send_ack;
		logic                 sda_in;
	} in_item_t;

	typedef struct packed {
		logic                 scl_level;
		logic                 sda_level;
		logic                 sda_drive_enable;
		logic                 busy_res;
		logic                 done_res;
		logic [BYTE_BITS-1:0] read_data;
		logic                 ack_received;
	} out_item_t;

endpackage
`default_nettype wire

/* design/i2cm_seq.sv */
`default_nettype none
module i2cm_seq (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire i2cm_pkg::in_item_t        item,
	input  wire logic [i2cm_pkg::HP_W-1:0] half_period,
	output i2cm_pkg::out_item_t            res
);

	localparam int BB = i2cm_pkg::BYTE_BITS;

	logic [2:0]                  phase_q, phase_n;
	logic [2:0]                  cmd_q, cmd_n;
	logic [i2cm_pkg::CNT_W-1:0]  bit_count_q, bit_count_n, bc_inc;
	logic [BB-1:0]               shift_q, shift_n;
	logic [i2cm_pkg::HP_W-1:0]   timer_q, timer_n, reload;
	logic                        ack_lat_q, ack_lat_n;
	logic                        scl_q, scl_n;
	logic                        sda_q, sda_n;
	logic                        oe_q, oe_n;
	logic [BB-1:0]               rbyte_q, rbyte_n;
	logic                        ack_in_q, ack_in_n;
	logic                        done_q, done_n;

	assign reload = (half_period == '0) ? '0 : half_period - 1'b1;
	assign bc_inc = bit_count_q + 1'b1;

	always_comb begin
		phase_n     = phase_q;
		cmd_n       = cmd_q;
		bit_count_n = bit_count_q;
		shift_n     = shift_q;
		timer_n     = timer_q;
		ack_lat_n   = ack_lat_q;
		scl_n       = scl_q;
		sda_n       = sda_q;
		oe_n        = oe_q;
		rbyte_n     = rbyte_q;
		ack_in_n    = ack_in_q;
		done_n      = 1'b0;
		if (phase_q == i2cm_pkg::PH_IDLE) begin
			if (item.cmd_valid && item.command <= i2cm_pkg::CMD_RACK) begin
				cmd_n       = item.command;
				bit_count_n = '0;
				phase_n     = i2cm_pkg::PH_HIGH;
				timer_n     = reload;
				scl_n       = 1'b1;
				unique case (item.command)
					i2cm_pkg::CMD_START: begin
						oe_n  = 1'b1;
						sda_n = 1'b1;
					end
					i2cm_pkg::CMD_STOP: begin
						oe_n  = 1'b1;
						sda_n = 1'b0;
					end
					i2cm_pkg::CMD_WRITE: begin
						shift_n = item.write_data;
						oe_n    = 1'b1;
						sda_n   = item.write_data[BB-1];
					end
					i2cm_pkg::CMD_READ: begin
						shift_n   = '0;
						ack_lat_n = item.send_ack;
						sda_n     = 1'b1;
						oe_n      = 1'b0;
					end
					i2cm_pkg::CMD_SACK: begin
						oe_n  = 1'b1;
						sda_n = ~item.send_ack;
					end
					default: begin
						oe_n = 1'b0;
					end
				endcase
			end
		end else if (timer_q != '0) begin
			timer_n = timer_q - 1'b1;
		end else begin
			unique case (phase_q)
				i2cm_pkg::PH_HIGH: begin
					if (cmd_q == i2cm_pkg::CMD_START) begin
						sda_n = 1'b0;
					end else if (cmd_q == i2cm_pkg::CMD_STOP) begin
						sda_n = 1'b1;
					end else begin
						if (cmd_q == i2cm_pkg::CMD_RACK) ack_in_n = item.sda_in;
						if (cmd_q == i2cm_pkg::CMD_READ) shift_n = {shift_q[BB-2:0], item.sda_in};
						scl_n = 1'b0;
					end
					phase_n = i2cm_pkg::PH_LOW;
					timer_n = reload;
				end
				i2cm_pkg::PH_LOW: begin
					if (cmd_q == i2cm_pkg::CMD_WRITE || cmd_q == i2cm_pkg::CMD_READ) begin
						bit_count_n = bc_inc;
						if (bc_inc >= i2cm_pkg::CNT_W'(BB)) begin
							if (cmd_q == i2cm_pkg::CMD_WRITE) begin
								phase_n = i2cm_pkg::PH_IDLE;
								timer_n = '0;
								done_n  = 1'b1;
							end else begin
								rbyte_n = shift_q;
								oe_n    = 1'b1;
								sda_n   = ~ack_lat_q;
								scl_n   = 1'b1;
								phase_n = i2cm_pkg::PH_AHIGH;
								timer_n = reload;
							end
						end else begin
							if (cmd_q == i2cm_pkg::CMD_WRITE) begin
								shift_n = {shift_q[BB-2:0], 1'b0};
								sda_n   = shift_q[BB-2];
							end
							scl_n   = 1'b1;
							phase_n = i2cm_pkg::PH_HIGH;
							timer_n = reload;
						end
					end else begin
						if (cmd_q == i2cm_pkg::CMD_START) scl_n = 1'b0;
						phase_n = i2cm_pkg::PH_IDLE;
						timer_n = '0;
						done_n  = 1'b1;
					end
				end
				i2cm_pkg::PH_AHIGH: begin
					scl_n   = 1'b0;
					phase_n = i2cm_pkg::PH_ALOW;
					timer_n = reload;
				end
				default: begin
					phase_n = i2cm_pkg::PH_IDLE;
					timer_n = '0;
					done_n  = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cm_pkg::PH_IDLE;
			cmd_q       <= i2cm_pkg::CMD_START;
			bit_count_q <= '0;
			shift_q     <= '0;
			timer_q     <= '0;
			ack_lat_q   <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			oe_q        <= 1'b1;
			rbyte_q     <= '0;
			ack_in_q    <= 1'b1;
			done_q      <= 1'b0;
		end else if (en) begin
			phase_q     <= phase_n;
			cmd_q       <= cmd_n;
			bit_count_q <= bit_count_n;
			shift_q     <= shift_n;
			timer_q     <= timer_n;
			ack_lat_q   <= ack_lat_n;
			scl_q       <= scl_n;
			sda_q       <= sda_n;
			oe_q        <= oe_n;
			rbyte_q     <= rbyte_n;
			ack_in_q    <= ack_in_n;
			done_q      <= done_n;
		end
	end

	// result of this tick, as the state stands after it
	always_comb begin
		res.scl_level        = scl_n;
		res.sda_level        = sda_n;
		res.sda_drive_enable = oe_n;
		res.busy_res         = (phase_n != i2cm_pkg::PH_IDLE);
		res.done_res         = done_n;
		res.read_data        = rbyte_n;
		res.ack_received     = ack_in_n;
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> phase_q == i2cm_pkg::PH_IDLE)
		else $error("done without returning to idle");

	a_idle_timer: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cm_pkg::PH_IDLE |-> timer_q == '0)
		else $error("timer running while idle");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= i2cm_pkg::CNT_W'(BB))
		else $error("bit count past byte length");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(phase_q) && $stable(timer_q) && $stable(shift_q))
		else $error("state moved without a step");

endmodule
`default_nettype wire

/* design/i2c_master_byte_engine_unit.sv */
`default_nettype none
// I2C master byte engine. Each input transfer is one bus tick carrying an optional command
// (start, stop, write byte, read byte with ACK/NACK, send ACK/NACK, receive ACK) and the
// sampled SDA level; each yields exactly one result transfer with the pin levels, busy, a
// done pulse, the last read byte and the last received ACK. One transfer is taken every
// clock cycle: a tick passes from the input register through the sequencer's next-state
// logic into the result register, and only a stalled result register holds the input back.
// Each SCL half-bit step lasts half_period_ticks ticks (zero acts as one); write it over
// cfg_wr_en/cfg_wr_data while idle.
module i2c_master_byte_engine_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire i2cm_pkg::in_item_t        in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output i2cm_pkg::out_item_t            out_data,
	input  wire logic                      cfg_wr_en,
	input  wire logic [i2cm_pkg::HP_W-1:0] cfg_wr_data
);

	logic                      valid_s1;
	i2cm_pkg::in_item_t        item_s1;
	logic                      out_valid_q;
	i2cm_pkg::out_item_t       out_data_q;
	logic [i2cm_pkg::HP_W-1:0] half_period_q;
	i2cm_pkg::out_item_t       res;
	logic                      adv;
	logic                      step;

	assign adv      = !out_valid_q || out_ready;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cm_pkg::HALF_PERIOD_RESET;
		end else if (cfg_wr_en) begin
			half_period_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	i2cm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (step),
		.item        (item_s1),
		.half_period (half_period_q),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

/* tb/i2c_master_byte_engine_unit_tb.sv */
`timescale 1ns / 100ps
module i2c_master_byte_engine_unit_tb;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_TICKS = 80;
	localparam int RANDOM_ROUNDS = 4;

	// codes outside the command set
	localparam logic [2:0] CMD_UNUSED_A = 3'd6;
	localparam logic [2:0] CMD_UNUSED_B = 3'd7;

	typedef enum {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_drive_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	i2cm_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	i2cm_pkg::out_item_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [i2cm_pkg::HP_W-1:0] cfg_wr_data = '0;

	i2c_master_byte_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	// bus sequencer state as predicted
	logic [i2cm_pkg::HP_W-1:0] half_period = i2cm_pkg::HALF_PERIOD_RESET;
	logic [2:0] bus_phase = i2cm_pkg::PH_IDLE;
	logic [2:0] bus_cmd = i2cm_pkg::CMD_START;
	int bit_total = 0;
	logic [i2cm_pkg::BYTE_BITS-1:0] shift_byte = '0;
	logic [i2cm_pkg::HP_W-1:0] step_timer = '0;
	logic ack_to_send = 1'b0;
	logic scl_now = 1'b1;
	logic sda_now = 1'b1;
	logic sda_oe_now = 1'b1;
	logic [i2cm_pkg::BYTE_BITS-1:0] last_read = '0;
	logic last_ack = 1'b1;

	i2cm_pkg::out_item_t pending_pins[$];
	i2cm_pkg::out_item_t want_pins;
	int mismatch_count = 0;
	int cycle_count = 0;
	int ticks_sent = 0;

	// sender and receiver pacing
	bit valid_up = 0;
	bit steady_send = 0;
	bit never_stall = 0;
	int burst_left = 4;
	logic [15:0] ready_pattern = 16'hFFFF;
	logic [6:0] pattern_age = '0;
	sda_drive_t slave_sda = SDA_RANDOM;

	task automatic enter_step(logic [2:0] next_phase);
		bus_phase = next_phase;
		step_timer = (half_period == 0) ? '0 : half_period - 1'b1;
	endtask

	task automatic launch_command(i2cm_pkg::in_item_t it);
		bus_cmd = it.command;
		bit_total = 0;
		case (it.command)
		i2cm_pkg::CMD_START: begin
			sda_oe_now = 1'b1;
			sda_now = 1'b1;
			scl_now = 1'b1;
		end
		i2cm_pkg::CMD_STOP: begin
			sda_oe_now = 1'b1;
			sda_now = 1'b0;
			scl_now = 1'b1;
		end
		i2cm_pkg::CMD_WRITE: begin
			shift_byte = it.write_data;
			sda_oe_now = 1'b1;
			sda_now = shift_byte[i2cm_pkg::BYTE_BITS-1];
			scl_now = 1'b1;
		end
		i2cm_pkg::CMD_READ: begin
			shift_byte = '0;
			ack_to_send = it.send_ack;
			sda_now = 1'b1;
			sda_oe_now = 1'b0;
			scl_now = 1'b1;
		end
		i2cm_pkg::CMD_SACK: begin
			sda_oe_now = 1'b1;
			sda_now = ~it.send_ack;
			scl_now = 1'b1;
		end
		i2cm_pkg::CMD_RACK: begin
			sda_oe_now = 1'b0;
			scl_now = 1'b1;
		end
		default: return;
		endcase
		enter_step(i2cm_pkg::PH_HIGH);
	endtask

	task automatic predict_pins(i2cm_pkg::in_item_t it);
		bit finished;
		i2cm_pkg::out_item_t r;
		finished = 0;
		if (bus_phase == i2cm_pkg::PH_IDLE) begin
			if (it.cmd_valid)
				launch_command(it);
		end else if (step_timer != 0) begin
			step_timer = step_timer - 1'b1;
		end else begin
			case (bus_phase)
			i2cm_pkg::PH_HIGH: begin
				if (bus_cmd == i2cm_pkg::CMD_START)
					sda_now = 1'b0;
				else if (bus_cmd == i2cm_pkg::CMD_STOP)
					sda_now = 1'b1;
				else begin
					if (bus_cmd == i2cm_pkg::CMD_RACK)
						last_ack = it.sda_in;
					if (bus_cmd == i2cm_pkg::CMD_READ)
						shift_byte = {shift_byte[i2cm_pkg::BYTE_BITS-2:0], it.sda_in};
					scl_now = 1'b0;
				end
				enter_step(i2cm_pkg::PH_LOW);
			end
			i2cm_pkg::PH_LOW: begin
				if (bus_cmd == i2cm_pkg::CMD_WRITE || bus_cmd == i2cm_pkg::CMD_READ) begin
					bit_total++;
					if (bit_total >= i2cm_pkg::BYTE_BITS) begin
						if (bus_cmd == i2cm_pkg::CMD_WRITE)
							finished = 1;
						else begin
							last_read = shift_byte;
							sda_oe_now = 1'b1;
							sda_now = ~ack_to_send;
							scl_now = 1'b1;
							enter_step(i2cm_pkg::PH_AHIGH);
						end
					end else begin
						if (bus_cmd == i2cm_pkg::CMD_WRITE) begin
							shift_byte = shift_byte << 1;
							sda_now = shift_byte[i2cm_pkg::BYTE_BITS-1];
						end
						scl_now = 1'b1;
						enter_step(i2cm_pkg::PH_HIGH);
					end
				end else begin
					if (bus_cmd == i2cm_pkg::CMD_START)
						scl_now = 1'b0;
					finished = 1;
				end
			end
			i2cm_pkg::PH_AHIGH: begin
				scl_now = 1'b0;
				enter_step(i2cm_pkg::PH_ALOW);
			end
			default: finished = 1;
			endcase
			if (finished) begin
				bus_phase = i2cm_pkg::PH_IDLE;
				step_timer = '0;
			end
		end
		r.scl_level = scl_now;
		r.sda_level = sda_now;
		r.sda_drive_enable = sda_oe_now;
		r.busy_res = (bus_phase != i2cm_pkg::PH_IDLE);
		r.done_res = finished;
		r.read_data = last_read;
		r.ack_received = last_ack;
		pending_pins.push_back(r);
	endtask

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("ERROR at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_pins.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want_pins = pending_pins.pop_front();
				check_field("scl_level", 8'(out_data.scl_level), 8'(want_pins.scl_level));
				check_field("sda_level", 8'(out_data.sda_level), 8'(want_pins.sda_level));
				check_field("sda_drive_enable", 8'(out_data.sda_drive_enable),
					8'(want_pins.sda_drive_enable));
				check_field("busy_res", 8'(out_data.busy_res), 8'(want_pins.busy_res));
				check_field("done_res", 8'(out_data.done_res), 8'(want_pins.done_res));
				check_field("read_data", out_data.read_data, want_pins.read_data);
				check_field("ack_received", 8'(out_data.ack_received),
					8'(want_pins.ack_received));
			end
		end
	end

	always @(posedge clk) begin
		if (never_stall)
			out_ready <= 1'b1;
		else
			out_ready <= ready_pattern[0];
		if (pattern_age == 0)
			ready_pattern <= 16'($urandom) | 16'h0001;
		else
			ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
		pattern_age <= pattern_age + 1'b1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic slave_bit();
		case (slave_sda)
		SDA_LOW: return 1'b0;
		SDA_HIGH: return 1'b1;
		default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic i2cm_pkg::in_item_t make_tick(logic v, logic [2:0] c, logic [7:0] d,
		logic a);
		i2cm_pkg::in_item_t it;
		it.cmd_valid = v;
		it.command = c;
		it.write_data = d;
		it.send_ack = a;
		it.sda_in = slave_bit();
		return it;
	endfunction

	task automatic send_tick(i2cm_pkg::in_item_t it);
		in_data <= it;
		if (!valid_up)
			in_valid <= 1'b1;
		valid_up = 1;
		do
			@(posedge clk);
		while (!in_ready);
		predict_pins(it);
		ticks_sent++;
		if (!steady_send) begin
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				valid_up = 0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	task automatic drop_valid();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 0;
		end
	endtask

	task automatic wait_drained();
		drop_valid();
		while (pending_pins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_half_period(logic [i2cm_pkg::HP_W-1:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		half_period = value;
	endtask

	// ticks while busy carry commands that must be ignored
	task automatic finish_command(bit force_valid);
		while (bus_phase != i2cm_pkg::PH_IDLE)
			send_tick(make_tick(force_valid | 1'($urandom_range(0, 1)),
				3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1))));
	endtask

	task automatic run_command(logic [2:0] c, logic [7:0] d, logic a, bit force_valid = 0);
		send_tick(make_tick(1'b1, c, d, a));
		finish_command(force_valid);
	endtask

	task automatic idle_tick();
		send_tick(make_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom),
			1'($urandom_range(0, 1))));
	endtask

	task automatic test_reset_half_period();
		slave_sda = SDA_RANDOM;
		idle_tick();
		run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0);
	endtask

	task automatic test_half_period_extremes();
		steady_send = 1;
		never_stall = 1;
		set_half_period(16'd9);
		run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
		steady_send = 0;
		never_stall = 0;
		set_half_period(16'h0000);
		run_command(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1);
		run_command(i2cm_pkg::CMD_SACK, 8'h00, 1'b1);
	endtask

	task automatic test_each_command();
		set_half_period(16'd1);
		slave_sda = SDA_RANDOM;
		run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0);
		run_command(i2cm_pkg::CMD_WRITE, 8'h00, 1'b0);
		run_command(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1);
		run_command(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0, 1);
		slave_sda = SDA_LOW;
		run_command(i2cm_pkg::CMD_RACK, 8'h00, 1'b0);
		run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b0);
		slave_sda = SDA_HIGH;
		run_command(i2cm_pkg::CMD_RACK, 8'h00, 1'b0);
		run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 1);
		slave_sda = SDA_RANDOM;
		run_command(i2cm_pkg::CMD_READ, 8'h5A, 1'b1);
		run_command(i2cm_pkg::CMD_SACK, 8'h00, 1'b1);
		run_command(i2cm_pkg::CMD_SACK, 8'hFF, 1'b0);
		run_command(CMD_UNUSED_A, 8'hFF, 1'b1);
		run_command(CMD_UNUSED_B, 8'h00, 1'b0);
		idle_tick();
		run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
	endtask

	task automatic pick_slave();
		case ($urandom_range(0, 5))
		0: slave_sda = SDA_LOW;
		1: slave_sda = SDA_HIGH;
		default: slave_sda = SDA_RANDOM;
		endcase
	endtask

	task automatic test_random_transfers();
		int goal;
		int n;
		for (int round = 0; round < RANDOM_ROUNDS; round++) begin
			case (round)
			0: set_half_period(16'd1);
			1: set_half_period(16'd2);
			2: set_half_period(16'd1);
			default: set_half_period(i2cm_pkg::HP_W'($urandom_range(1, 3)));
			endcase
			steady_send = (round == 1);
			never_stall = (round == 2);
			goal = ticks_sent + RANDOM_TICKS / RANDOM_ROUNDS;
			while (ticks_sent < goal) begin
				pick_slave();
				if ($urandom_range(0, 4) == 0) begin
					if ($urandom_range(0, 1))
						repeat ($urandom_range(1, 3)) idle_tick();
					else
						run_command(3'($urandom_range(0, 7)), 8'($urandom),
							1'($urandom_range(0, 1)));
				end else begin
					run_command(i2cm_pkg::CMD_START, 8'($urandom),
						1'($urandom_range(0, 1)));
					run_command(i2cm_pkg::CMD_WRITE, 8'($urandom),
						1'($urandom_range(0, 1)));
					pick_slave();
					run_command(i2cm_pkg::CMD_RACK, 8'($urandom), 1'($urandom_range(0, 1)));
					n = $urandom_range(0, 3);
					repeat (n) begin
						pick_slave();
						if ($urandom_range(0, 1)) begin
							run_command(i2cm_pkg::CMD_WRITE, 8'($urandom),
								1'($urandom_range(0, 1)));
							run_command(i2cm_pkg::CMD_RACK, 8'($urandom),
								1'($urandom_range(0, 1)));
						end else begin
							run_command(i2cm_pkg::CMD_READ, 8'($urandom),
								1'($urandom_range(0, 1)));
						end
					end
					if ($urandom_range(0, 3) == 0)
						run_command(i2cm_pkg::CMD_SACK, 8'($urandom),
							1'($urandom_range(0, 1)));
					if ($urandom_range(0, 7) != 0)
						run_command(i2cm_pkg::CMD_STOP, 8'($urandom),
							1'($urandom_range(0, 1)));
				end
			end
		end
		steady_send = 0;
		never_stall = 0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_half_period();
		test_half_period_extremes();
		test_each_command();
		test_random_transfers();
		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_pins.size() != 0)
			report_mismatch("expected results left over");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
